/* rtl/assert_macros.svh */
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define BLE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define BLE_ASSERT_NEVER(label, cond, msg) \
  `BLE_ASSERT(label, !(cond), msg)

`endif

/* rtl/ble_pkg.sv */
// package for the battery level estimator: widths, lut, codes and control structs
package ble_pkg;

  localparam int CODE_W   = 12;
  localparam int VREF_W   = 12;
  localparam int MV_W     = 16;
  localparam int RATIO_W  = 8;
  localparam int PCT_W    = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam int HIST_DEPTH = 8;
  localparam int PTR_W      = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int CNT_W      = $clog2(HIST_DEPTH + 1);
  localparam int SUM_W      = MV_W + CNT_W;

  localparam int DIVD_W  = CODE_W + VREF_W;
  localparam int DIVS_W  = 16;
  localparam int DCNT_W  = $clog2(DIVD_W + 1);
  localparam int BAT_W   = DIVD_W + RATIO_W;
  localparam int FRAC_W  = 4;

  localparam logic [MV_W-1:0] AVERAGE_RESET = 16'd4000;

  localparam logic [CFG_IDX_W-1:0] CFG_VREF       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ADC_FS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCONNECT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL   = 3'd5;

  localparam int LUT_POINTS = 11;
  localparam int LUT_SEGS   = LUT_POINTS - 1;
  localparam int SEG_W      = 4;
  localparam int SPAN_W     = 9;
  localparam int PD_W       = 5;
  localparam int NUM_W      = SPAN_W + PD_W;

  localparam logic [MV_W-1:0] LUT_MV [LUT_POINTS] = '{
    16'd4180, 16'd4050, 16'd3950, 16'd3850, 16'd3800, 16'd3750,
    16'd3700, 16'd3650, 16'd3550, 16'd3400, 16'd3100
  };
  localparam logic [PCT_W-1:0] LUT_PCT [LUT_POINTS] = '{
    7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50, 7'd30, 7'd20, 7'd10, 7'd5, 7'd0
  };
  localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
  localparam logic [PCT_W-1:0] PCT_EMPTY = 7'd0;

  typedef enum logic [1:0] {
    DIV_SCALE,
    DIV_AVG,
    DIV_PCT
  } div_sel_e;

  typedef struct packed {
    logic     take_code;
    logic     prod_load;
    logic     div_start;
    div_sel_e div_sel;
    logic     ratio_load;
    logic     store;
    logic     sum_run;
    logic     avg_load;
    logic     seg_load;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic sum_done;
  } sts_t;

endpackage

/* rtl/battery_level_estimator_top.sv */
// top level of the battery level estimator
// Takes one 12-bit adc code per request and returns the battery voltage of the sample, the
// moving average over the last eight samples (fewer after reset), the lipo charge percent
// interpolated from that average, and the low, critical and connected flags. Most of the work
// of a request is the shared 24-step divider, run once for the millivolt scaling, once for the
// mean after a sweep over the stored samples of the averaging window (1 to 8) and once for the
// interpolation. A finished result waits in the output register while the next request is
// taken. The user must write configuration through the cfg port only while idle; the block
// itself does not enforce it.
`include "assert_macros.svh"

module battery_level_estimator_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [ble_pkg::CODE_W-1:0]     adc_code_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ble_pkg::CODE_W-1:0]     code_echo_o,
  output logic [ble_pkg::MV_W-1:0]       sample_mv_o,
  output logic [ble_pkg::MV_W-1:0]       average_mv_o,
  output logic [ble_pkg::PCT_W-1:0]      charge_percent_o,
  output logic                           low_flag_o,
  output logic                           critical_flag_o,
  output logic                           connected_flag_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ble_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ble_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import ble_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  ble_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ble_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .adc_code_i       (adc_code_i),
    .cfg_we_i         (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .code_echo_o      (code_echo_o),
    .sample_mv_o      (sample_mv_o),
    .average_mv_o     (average_mv_o),
    .charge_percent_o (charge_percent_o),
    .low_flag_o       (low_flag_o),
    .critical_flag_o  (critical_flag_o),
    .connected_flag_o (connected_flag_o)
  );

  `BLE_ASSERT(a_busy_after_accept, (in_valid_i && in_ready_o) |=> !in_ready_o, "ready after accept")
  `BLE_ASSERT(a_load_when_free, cmd.out_load |-> (!out_valid_o || out_ready_i), "result overwritten")
  `BLE_ASSERT_NEVER(a_start_while_busy, cmd.div_start && sts.div_busy, "divider restarted")
  `BLE_ASSERT(a_valid_from_load, $rose(out_valid_o) |-> $past(cmd.out_load), "result without load")

endmodule

/* rtl/ble_div.sv */
// shared restoring divider, one quotient bit per cycle
module ble_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ble_pkg::DIVD_W-1:0] dividend_i,
  input  logic [ble_pkg::DIVS_W-1:0] divisor_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [ble_pkg::DIVD_W-1:0] quotient_o
);
  import ble_pkg::*;

  logic [DIVS_W-1:0] rem_q;
  logic [DIVD_W-1:0] quo_q;
  logic [DIVS_W-1:0] dvs_q;
  logic [DCNT_W-1:0] cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [DIVS_W:0]   shl;
  logic [DIVS_W:0]   diff;
  logic              ge;

  assign shl  = {rem_q, quo_q[DIVD_W-1]};
  assign ge   = shl >= {1'b0, dvs_q};
  assign diff = shl - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DCNT_W'(DIVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DCNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DIVS_W-1:0] : shl[DIVS_W-1:0];
      quo_q <= {quo_q[DIVD_W-2:0], ge};
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* rtl/ble_datapath.sv */
// datapath: config registers, scaling, sample history, averaging and charge lookup
module ble_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ble_pkg::cmd_t                  cmd_i,
  output ble_pkg::sts_t                  sts_o,
  input  logic [ble_pkg::CODE_W-1:0]     adc_code_i,
  input  logic                           cfg_we_i,
  input  logic [ble_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ble_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic [ble_pkg::CODE_W-1:0]     code_echo_o,
  output logic [ble_pkg::MV_W-1:0]       sample_mv_o,
  output logic [ble_pkg::MV_W-1:0]       average_mv_o,
  output logic [ble_pkg::PCT_W-1:0]      charge_percent_o,
  output logic                           low_flag_o,
  output logic                           critical_flag_o,
  output logic                           connected_flag_o
);
  import ble_pkg::*;

  logic [VREF_W-1:0]  vref_q;
  logic [MV_W-1:0]    adc_fs_q;
  logic [RATIO_W-1:0] ratio_q;
  logic [MV_W-1:0]    disc_q;
  logic [MV_W-1:0]    low_q;
  logic [MV_W-1:0]    crit_q;

  logic [CODE_W-1:0]  code_q;
  logic [DIVD_W-1:0]  prod_q;
  logic [BAT_W-1:0]   bat_q;
  logic [MV_W-1:0]    sample_q;
  logic [MV_W-1:0]    sample_sat;
  logic [MV_W-1:0]    hist_q [HIST_DEPTH];
  logic [PTR_W-1:0]   wp_q;
  logic [CNT_W-1:0]   fill_q;
  logic [CNT_W-1:0]   sum_idx_q;
  logic               rd_vld_q;
  logic               rd_en;
  logic [MV_W-1:0]    rd_q;
  logic [SUM_W-1:0]   sum_q;
  logic [MV_W-1:0]    avg_q;

  logic [SEG_W-1:0]   seg_c;
  logic [SEG_W-1:0]   seg_q;
  logic [MV_W-1:0]    seg_diff;
  logic [PCT_W-1:0]   seg_pd;
  logic [NUM_W-1:0]   num_c;
  logic [NUM_W-1:0]   num_q;
  logic [MV_W-1:0]    span;
  logic               dir_c;
  logic [PCT_W-1:0]   dir_pct_c;
  logic               dir_q;
  logic [PCT_W-1:0]   dir_pct_q;
  logic [PCT_W-1:0]   pct_c;

  logic [DIVD_W-1:0]  div_dividend;
  logic [DIVS_W-1:0]  div_divisor;
  logic [DIVD_W-1:0]  div_quo;
  logic               div_busy;
  logic               div_done;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vref_q   <= 12'd2420;
      adc_fs_q <= 16'd4095;
      ratio_q  <= 8'd32;
      disc_q   <= 16'd2000;
      low_q    <= 16'd3650;
      crit_q   <= 16'd3400;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_VREF:       vref_q   <= cfg_data_i[VREF_W-1:0];
        CFG_ADC_FS:     adc_fs_q <= cfg_data_i;
        CFG_RATIO:      ratio_q  <= cfg_data_i[RATIO_W-1:0];
        CFG_DISCONNECT: disc_q   <= cfg_data_i;
        CFG_LOW:        low_q    <= cfg_data_i;
        CFG_CRITICAL:   crit_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // divider operand select
  always_comb begin
    unique case (cmd_i.div_sel)
      DIV_SCALE: begin
        div_dividend = prod_q;
        div_divisor  = (adc_fs_q == '0) ? DIVS_W'(1) : adc_fs_q;
      end
      DIV_AVG: begin
        div_dividend = DIVD_W'(sum_q);
        div_divisor  = DIVS_W'(fill_q);
      end
      DIV_PCT: begin
        div_dividend = DIVD_W'(num_q);
        div_divisor  = span;
      end
      default: begin
        div_dividend = prod_q;
        div_divisor  = DIVS_W'(1);
      end
    endcase
  end

  ble_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // saturate after dropping the q4 fraction
  assign sample_sat = (|bat_q[BAT_W-1:MV_W+FRAC_W]) ? '1 : bat_q[MV_W+FRAC_W-1:FRAC_W];

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_code) begin
      code_q <= adc_code_i;
    end
    if (cmd_i.prod_load) begin
      prod_q <= DIVD_W'(code_q) * DIVD_W'(vref_q);
    end
    if (cmd_i.ratio_load) begin
      bat_q <= BAT_W'(div_quo) * BAT_W'(ratio_q);
    end
    if (cmd_i.store) begin
      sample_q <= sample_sat;
    end
    if (cmd_i.avg_load) begin
      avg_q <= div_quo[MV_W-1:0];
    end
  end

  // history memory, one write and one registered read port
  assign rd_en = cmd_i.sum_run && (sum_idx_q != fill_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      hist_q[wp_q] <= sample_sat;
    end
    if (rd_en) begin
      rd_q <= hist_q[sum_idx_q[PTR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      fill_q    <= '0;
      sum_idx_q <= '0;
      rd_vld_q  <= 1'b0;
    end else if (cmd_i.store) begin
      wp_q      <= (wp_q == PTR_W'(HIST_DEPTH - 1)) ? '0 : wp_q + 1'b1;
      fill_q    <= (fill_q == CNT_W'(HIST_DEPTH)) ? fill_q : fill_q + 1'b1;
      sum_idx_q <= '0;
      rd_vld_q  <= 1'b0;
    end else if (cmd_i.sum_run) begin
      if (rd_en) begin
        sum_idx_q <= sum_idx_q + 1'b1;
      end
      rd_vld_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      sum_q <= '0;
    end else if (cmd_i.sum_run && rd_vld_q) begin
      sum_q <= sum_q + SUM_W'(rd_q);
    end
  end

  // segment search, first match from the top
  always_comb begin
    seg_c = SEG_W'(LUT_SEGS - 1);
    for (int i = LUT_SEGS - 1; i >= 0; i--) begin
      if (avg_q >= LUT_MV[i+1]) begin
        seg_c = SEG_W'(i);
      end
    end
  end

  assign seg_diff  = avg_q - LUT_MV[seg_c + 4'd1];
  assign seg_pd    = LUT_PCT[seg_c] - LUT_PCT[seg_c + 4'd1];
  assign num_c     = NUM_W'(seg_diff[SPAN_W-1:0]) * NUM_W'(seg_pd[PD_W-1:0]);
  assign dir_c     = (avg_q < disc_q) || (avg_q >= LUT_MV[0])
                     || (avg_q <= LUT_MV[LUT_POINTS-1]);
  assign dir_pct_c = ((avg_q >= disc_q) && (avg_q >= LUT_MV[0])) ? PCT_FULL : PCT_EMPTY;
  assign span      = LUT_MV[seg_q] - LUT_MV[seg_q + 4'd1];

  always_ff @(posedge clk_i) begin
    if (cmd_i.seg_load) begin
      seg_q     <= seg_c;
      num_q     <= num_c;
      dir_q     <= dir_c;
      dir_pct_q <= dir_pct_c;
    end
  end

  assign pct_c = dir_q ? dir_pct_q : LUT_PCT[seg_q + 4'd1] + div_quo[PCT_W-1:0];

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      code_echo_o      <= code_q;
      sample_mv_o      <= sample_q;
      average_mv_o     <= avg_q;
      charge_percent_o <= pct_c;
      low_flag_o       <= avg_q <= low_q;
      critical_flag_o  <= avg_q <= crit_q;
      connected_flag_o <= avg_q >= disc_q;
    end
  end

  assign sts_o.div_busy = div_busy;
  assign sts_o.div_done = div_done;
  assign sts_o.sum_done = (sum_idx_q == fill_q) && !rd_vld_q;

endmodule

/* rtl/ble_ctrl.sv */
// controller: sequences one request through the datapath and drives the handshakes
module ble_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  ble_pkg::sts_t sts_i,
  output ble_pkg::cmd_t cmd_o
);
  import ble_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROD,
    ST_SCALE_GO,
    ST_SCALE_WAIT,
    ST_RATIO,
    ST_STORE,
    ST_SUM,
    ST_AVG_GO,
    ST_AVG_WAIT,
    ST_SEG,
    ST_PCT_GO,
    ST_PCT_WAIT,
    ST_DONE
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   out_valid_q;
  logic   out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o           = '0;
    cmd_o.div_sel   = DIV_SCALE;
    state_d         = state_q;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.take_code = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_PROD;
        end
      end
      ST_PROD: begin
        cmd_o.prod_load = 1'b1;
        state_d         = ST_SCALE_GO;
      end
      ST_SCALE_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_SCALE_WAIT;
      end
      ST_SCALE_WAIT: begin
        if (sts_i.div_done) begin
          state_d = ST_RATIO;
        end
      end
      ST_RATIO: begin
        cmd_o.ratio_load = 1'b1;
        state_d          = ST_STORE;
      end
      ST_STORE: begin
        cmd_o.store = 1'b1;
        state_d     = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum_run = 1'b1;
        if (sts_i.sum_done) begin
          state_d = ST_AVG_GO;
        end
      end
      ST_AVG_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_AVG;
        state_d         = ST_AVG_WAIT;
      end
      ST_AVG_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.avg_load = 1'b1;
          state_d        = ST_SEG;
        end
      end
      ST_SEG: begin
        cmd_o.seg_load = 1'b1;
        state_d        = ST_PCT_GO;
      end
      ST_PCT_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_PCT;
        state_d         = ST_PCT_WAIT;
      end
      ST_PCT_WAIT: begin
        if (sts_i.div_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd_o.out_load = out_free;
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* sim/battery_level_estimator_top_test.sv */
// testbench for the battery level estimator: directed and random adc requests checked against a predictor
`timescale 1ns / 100ps

module battery_level_estimator_top_test;

  localparam int WINDOW = 8;
  localparam int HOLD_CYCLES = 600;
  localparam logic [11*16-1:0] KNEE_MV = {
    16'd4180, 16'd4050, 16'd3950, 16'd3850, 16'd3800, 16'd3750,
    16'd3700, 16'd3650, 16'd3550, 16'd3400, 16'd3100
  };
  localparam logic [11*8-1:0] KNEE_PCT = {
    8'd100, 8'd90, 8'd80, 8'd70, 8'd60, 8'd50, 8'd30, 8'd20, 8'd10, 8'd5, 8'd0
  };

  typedef struct packed {
    logic [11:0] code;
    logic [15:0] sample;
    logic [15:0] average;
    logic [6:0]  percent;
    logic        low;
    logic        critical;
    logic        connected;
  } gauge_result_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             in_valid_i;
  logic                             in_ready_o;
  logic [ble_pkg::CODE_W-1:0]       adc_code_i;
  logic                             out_valid_o;
  logic                             out_ready_i;
  logic [ble_pkg::CODE_W-1:0]       code_echo_o;
  logic [ble_pkg::MV_W-1:0]         sample_mv_o;
  logic [ble_pkg::MV_W-1:0]         average_mv_o;
  logic [ble_pkg::PCT_W-1:0]        charge_percent_o;
  logic                             low_flag_o;
  logic                             critical_flag_o;
  logic                             connected_flag_o;
  logic                             cfg_valid_i;
  logic                             cfg_ready_o;
  logic [ble_pkg::CFG_IDX_W-1:0]    cfg_index_i;
  logic [ble_pkg::CFG_DATA_W-1:0]   cfg_data_i;

  logic [11:0]     cfg_vref;
  logic [15:0]     cfg_full_scale;
  logic [7:0]      cfg_ratio;
  logic [15:0]     cfg_disconnect;
  logic [15:0]     cfg_low;
  logic [15:0]     cfg_critical;
  logic [15:0]     window_mv [WINDOW];
  int              window_wr;
  int              window_fill;
  gauge_result_t   pending_results [$];
  int              mismatches;
  bit              sender_gaps;
  bit              receiver_stalls;
  bit              hold_pending;

  battery_level_estimator_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .adc_code_i       (adc_code_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .code_echo_o      (code_echo_o),
    .sample_mv_o      (sample_mv_o),
    .average_mv_o     (average_mv_o),
    .charge_percent_o (charge_percent_o),
    .low_flag_o       (low_flag_o),
    .critical_flag_o  (critical_flag_o),
    .connected_flag_o (connected_flag_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [6:0] soc_percent(input logic [15:0] mv);
    int avg, hi_mv, lo_mv, hi_pct, lo_pct;
    avg = mv;
    if (mv < cfg_disconnect) return 7'd0;
    if (avg >= KNEE_MV[16*10 +: 16]) return 7'd100;
    if (avg <= KNEE_MV[0 +: 16]) return 7'd0;
    for (int k = 0; k < 10; k++) begin
      hi_mv  = KNEE_MV[16*(10-k) +: 16];
      lo_mv  = KNEE_MV[16*(9-k) +: 16];
      hi_pct = KNEE_PCT[8*(10-k) +: 8];
      lo_pct = KNEE_PCT[8*(9-k) +: 8];
      if (avg <= hi_mv && avg >= lo_mv) begin
        return 7'(lo_pct + (avg - lo_mv) * (hi_pct - lo_pct) / (hi_mv - lo_mv));
      end
    end
    return 7'd0;
  endfunction

  function automatic gauge_result_t predict_gauge(input logic [11:0] code);
    longint unsigned divisor, pin_mv, bat_mv;
    int unsigned sum;
    gauge_result_t r;
    divisor = (cfg_full_scale == 16'd0) ? 64'd1 : 64'(cfg_full_scale);
    pin_mv = (64'(code) * 64'(cfg_vref)) / divisor;
    bat_mv = (pin_mv * 64'(cfg_ratio)) >> 4;
    r.code = code;
    r.sample = (bat_mv > 64'hFFFF) ? 16'hFFFF : bat_mv[15:0];
    window_mv[window_wr] = r.sample;
    window_wr = (window_wr + 1 >= WINDOW) ? 0 : window_wr + 1;
    if (window_fill < WINDOW) window_fill++;
    sum = 0;
    for (int i = 0; i < window_fill; i++) sum += window_mv[i];
    r.average = 16'(sum / window_fill);
    r.percent = soc_percent(r.average);
    r.low = (r.average <= cfg_low);
    r.critical = (r.average <= cfg_critical);
    r.connected = (r.average >= cfg_disconnect);
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("mismatch on %s at %0t: got %0d, expected %0d", field, $realtime, got, want);
    mismatches++;
  endtask

  task automatic send_code(input logic [11:0] code);
    int gap;
    gap = sender_gaps ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    adc_code_i <= code;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(predict_gauge(code));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic apply_config(input logic [15:0] vref, input logic [15:0] full_scale,
                              input logic [15:0] ratio, input logic [15:0] disconnect,
                              input logic [15:0] low, input logic [15:0] critical);
    logic [ble_pkg::CFG_IDX_W-1:0] idx [6];
    logic [15:0] val [6];
    wait_drained();
    idx[0] = ble_pkg::CFG_VREF;       val[0] = vref;
    idx[1] = ble_pkg::CFG_ADC_FS;     val[1] = full_scale;
    idx[2] = ble_pkg::CFG_RATIO;      val[2] = ratio;
    idx[3] = ble_pkg::CFG_DISCONNECT; val[3] = disconnect;
    idx[4] = ble_pkg::CFG_LOW;        val[4] = low;
    idx[5] = ble_pkg::CFG_CRITICAL;   val[5] = critical;
    for (int i = 0; i < 6; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (idx[i])
        ble_pkg::CFG_VREF:       cfg_vref = val[i][11:0];
        ble_pkg::CFG_ADC_FS:     cfg_full_scale = val[i];
        ble_pkg::CFG_RATIO:      cfg_ratio = val[i][7:0];
        ble_pkg::CFG_DISCONNECT: cfg_disconnect = val[i];
        ble_pkg::CFG_LOW:        cfg_low = val[i];
        ble_pkg::CFG_CRITICAL:   cfg_critical = val[i];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [15:0] extreme_or_random();
    case ($urandom_range(0, 2))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // reset values, window filling and wrapping, table ends and absent battery
  task automatic test_reset_defaults();
    logic [11:0] codes [12];
    codes = '{12'd4095, 12'd0, 12'd0, 12'd3300, 12'd3300, 12'd3300, 12'd3300,
              12'd3300, 12'd3300, 12'd3300, 12'd3100, 12'd2900};
    sender_gaps = 1'b1;
    receiver_stalls = 1'b1;
    foreach (codes[i]) send_code(codes[i]);
  endtask

  // upper register bits ignored, sample saturation
  task automatic test_saturation();
    apply_config(16'hFFFF, 16'd1, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF);
    send_code(12'd4095);
    send_code(12'd1);
    send_code(12'd0);
    send_code(12'd2048);
  endtask

  // a zero full-scale code divides by one
  task automatic test_zero_full_scale();
    apply_config(16'hF001, 16'd0, 16'd16, 16'hFFFF, 16'd0, 16'd0);
    send_code(12'd4095);
    send_code(12'd0);
    send_code(12'd1);
  endtask

  task automatic test_minimum_scale();
    apply_config(16'd1, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd0);
    send_code(12'd4095);
    send_code(12'd0);
  endtask

  // output held off for a long stretch so the block stops taking requests
  task automatic test_backpressure();
    apply_config(16'd2420, 16'd4095, 16'd32, 16'd2000, 16'd3650, 16'd3400);
    sender_gaps = 1'b0;
    hold_pending = 1'b1;
    repeat (12) send_code(12'($urandom_range(2600, 3500)));
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int kind, center, spread, code, burst;
    for (int phase = 0; phase < 12; phase++) begin
      kind = (phase == 0) ? 0 : $urandom_range(0, 3);
      case (kind)
        0, 1: apply_config(16'd2420, 16'd4095, 16'd32, 16'($urandom_range(1500, 3300)),
                           16'($urandom_range(3300, 3900)), 16'($urandom_range(3000, 3600)));
        2: apply_config(16'($urandom_range(1800, 3300)), 16'($urandom_range(3000, 4095)),
                        16'($urandom_range(24, 48)), 16'($urandom_range(2500, 4300)),
                        16'($urandom_range(2500, 4300)), 16'($urandom_range(2500, 4300)));
        default: apply_config(extreme_or_random(), extreme_or_random(), extreme_or_random(),
                              extreme_or_random(), extreme_or_random(), extreme_or_random());
      endcase
      sender_gaps = (phase != 0) && ($urandom_range(0, 3) != 0);
      receiver_stalls = (phase != 0) && ($urandom_range(0, 3) != 0);
      burst = 0;
      for (int n = 0; n < 95; n++) begin
        if (burst == 0) begin
          burst = $urandom_range(8, 24);
          center = (kind == 3) ? int'($urandom_range(0, 4095)) : int'($urandom_range(2500, 3650));
          spread = $urandom_range(0, 60);
        end
        burst--;
        if ($urandom_range(0, 9) == 0) begin
          code = $urandom_range(0, 4095);
        end else begin
          code = center + int'($urandom_range(0, 2 * spread)) - spread;
          if (code < 0) code = 0;
          if (code > 4095) code = 4095;
        end
        send_code(12'(code));
        // sender pauses until the pipeline is empty
        if (phase == 6 && n == 40) wait_drained();
      end
    end
  endtask

  initial begin
    int stall;
    gauge_result_t want;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = receiver_stalls ? $urandom_range(0, 15) : 0;
      if (hold_pending) begin
        hold_pending = 1'b0;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        do @(posedge clk_i); while (!out_valid_o);
        repeat (stall - 1) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (pending_results.size() == 0) begin
        report_mismatch("result without request", code_echo_o, 0);
      end else begin
        want = pending_results.pop_front();
        if (code_echo_o !== want.code)
          report_mismatch("code_echo", code_echo_o, want.code);
        if (sample_mv_o !== want.sample)
          report_mismatch("sample_mv", sample_mv_o, want.sample);
        if (average_mv_o !== want.average)
          report_mismatch("average_mv", average_mv_o, want.average);
        if (charge_percent_o !== want.percent)
          report_mismatch("charge_percent", charge_percent_o, want.percent);
        if (low_flag_o !== want.low)
          report_mismatch("low_flag", low_flag_o, want.low);
        if (critical_flag_o !== want.critical)
          report_mismatch("critical_flag", critical_flag_o, want.critical);
        if (connected_flag_o !== want.connected)
          report_mismatch("connected_flag", connected_flag_o, want.connected);
      end
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    adc_code_i  <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= ble_pkg::CFG_VREF;
    cfg_data_i  <= '0;
    cfg_vref       = 12'd2420;
    cfg_full_scale = 16'd4095;
    cfg_ratio      = 8'd32;
    cfg_disconnect = 16'd2000;
    cfg_low        = 16'd3650;
    cfg_critical   = 16'd3400;
    window_wr   = 0;
    window_fill = 0;
    mismatches  = 0;
    sender_gaps = 1'b0;
    receiver_stalls = 1'b0;
    hold_pending = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_saturation();
    test_zero_full_scale();
    test_minimum_scale();
    test_backpressure();
    test_random_traffic();

    wait_drained();
    repeat (100) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch("results still outstanding", pending_results.size(), 0);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
